@@ hw/rtl/lmps_pkg.sv @@
// Shared types, constants and helper functions for the LED matrix PWM scanner.
`default_nettype none

package lmps_pkg;

    // Widest field widths over the supported parameter ranges.
    localparam int IDX_MAX_W   = 8;   // byte index within one buffer
    localparam int WORD_MAX_W  = 6;   // word (group of four bytes) index
    localparam int COL_MAX_W   = 5;   // scan column
    localparam int LEVEL_MAX_W = 8;   // PWM phase

    // Buffer organization: four byte lanes make up one column word.
    localparam int BYTE_LANES  = 4;
    localparam int LANE_W      = 2;
    localparam int BUFFER_COUNT = 2;

    // Number of rows and of column lines on the matrix.
    localparam int SCAN_ROWS   = 8;

    // Decoupling queue between the front and back parts.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;

    // Buffer identifiers.
    localparam logic BUF_ONE = 1'b0;
    localparam logic BUF_TWO = 1'b1;

    // Kind of work the back part carries out for one transaction.
    typedef enum logic [1:0] {
        OP_WRITE,
        OP_SWAP,
        OP_SCAN
    } op_kind_t;

    // One classified transaction travelling through the queue.
    typedef struct packed {
        op_kind_t                kind;
        logic                    buf_sel;
        logic [WORD_MAX_W-1:0]   wr_word;
        logic [LANE_W-1:0]       wr_lane;
        logic [WORD_MAX_W-1:0]   rd_word;
        logic [LANE_W-1:0]       rd_lane;
        logic [7:0]              data;
        logic [7:0]              col_drive;
        logic [LEVEL_MAX_W-1:0]  phase;
    } op_t;

    // Contents of a buffer byte that has not been written since reset.
    // Buffer one starts as a gradient, one level per column; buffer two is dark.
    function automatic logic [7:0] init_byte(input logic buf_sel,
                                             input logic [WORD_MAX_W-1:0] word);
        logic [7:0] value;
        begin
            if (buf_sel == BUF_ONE)
            begin
                value = {word[3:0], word[3:0]};
            end
            else
            begin
                value = 8'h00;
            end
            return value;
        end
    endfunction

endpackage : lmps_pkg

`default_nettype wire

@@ hw/rtl/lmps_front.sv @@
// Front part: classifies each input transaction and keeps the scan and write state.
`default_nettype none

module lmps_front
    import lmps_pkg::*;
#(
    parameter int BUFFER_BYTES = 32,
    parameter int COLUMNS      = 8,
    parameter int PWM_LEVELS   = 16
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic accept,
    input  wire logic mode,
    input  wire logic [7:0] data_in,
    input  wire logic select_high,
    output op_t       op
);

    localparam int IDX_W  = $clog2(BUFFER_BYTES);
    localparam int WORDS  = BUFFER_BYTES / BYTE_LANES;
    localparam int WORD_W = $clog2(WORDS);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int PH_W   = $clog2(PWM_LEVELS);

    logic [IDX_W-1:0]  write_index_reg, write_index_next;
    logic              swap_pending_reg, swap_pending_next;
    logic              front_select_reg, front_select_next;
    logic [COL_W-1:0]  scan_column_reg, scan_column_next;
    logic [WORD_W-1:0] scan_word_reg, scan_word_next;
    logic [PH_W-1:0]   pwm_phase_reg, pwm_phase_next;

    logic [IDX_W-1:0]     index_after;
    logic                 do_swap;
    logic                 column_last;
    logic                 word_last;
    logic [COL_MAX_W-1:0] column_ext;
    logic [7:0]           column_pattern;

    // Index of the byte after the write position, wrapping at the buffer end.
    assign index_after = (write_index_reg == IDX_W'(BUFFER_BYTES - 1)) ? '0
                       : write_index_reg + 1'b1;

    // A swap is taken only at the start of a frame with a pending update.
    assign do_swap = mode && (scan_column_reg == '0) && swap_pending_reg && select_high;

    assign column_last = (scan_column_reg == COL_W'(COLUMNS - 1));
    assign word_last   = (scan_word_reg == WORD_W'(WORDS - 1));

    // Active-low column select; columns past the eighth select nothing.
    assign column_ext = COL_MAX_W'(scan_column_reg);
    assign column_pattern = (column_ext < COL_MAX_W'(SCAN_ROWS))
                          ? ~(8'h01 << column_ext[2:0]) : 8'hFF;

    // Classify the transaction and build the work item for the back part.
    always_comb
    begin
        op = '0;
        op.data      = data_in;
        op.col_drive = column_pattern;
        op.phase     = LEVEL_MAX_W'(pwm_phase_reg);
        if (!mode)
        begin
            op.kind    = OP_WRITE;
            op.buf_sel = ~front_select_reg;
            op.wr_word = WORD_MAX_W'(write_index_reg[IDX_W-1:LANE_W]);
            op.wr_lane = write_index_reg[LANE_W-1:0];
            op.rd_word = WORD_MAX_W'(index_after[IDX_W-1:LANE_W]);
            op.rd_lane = index_after[LANE_W-1:0];
        end
        else if (do_swap)
        begin
            op.kind    = OP_SWAP;
            op.buf_sel = front_select_reg;
        end
        else
        begin
            op.kind    = OP_SCAN;
            op.buf_sel = front_select_reg;
            op.rd_word = WORD_MAX_W'(scan_word_reg);
        end
    end

    // Next values of the front state.
    always_comb
    begin
        write_index_next  = write_index_reg;
        swap_pending_next = swap_pending_reg;
        front_select_next = front_select_reg;
        scan_column_next  = scan_column_reg;
        scan_word_next    = scan_word_reg;
        pwm_phase_next    = pwm_phase_reg;
        if (accept)
        begin
            if (!mode)
            begin
                write_index_next  = index_after;
                swap_pending_next = 1'b1;
            end
            else if (do_swap)
            begin
                front_select_next = ~front_select_reg;
                swap_pending_next = 1'b0;
            end
            else if (column_last)
            begin
                scan_column_next = '0;
                scan_word_next   = '0;
                pwm_phase_next   = (pwm_phase_reg == PH_W'(PWM_LEVELS - 1)) ? '0
                                 : pwm_phase_reg + 1'b1;
            end
            else
            begin
                scan_column_next = scan_column_reg + 1'b1;
                scan_word_next   = word_last ? '0 : scan_word_reg + 1'b1;
            end
        end
    end

    // Front state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_index_reg  <= '0;
            swap_pending_reg <= 1'b0;
            front_select_reg <= BUF_ONE;
            scan_column_reg  <= '0;
            scan_word_reg    <= '0;
            pwm_phase_reg    <= '0;
        end
        else
        begin
            write_index_reg  <= write_index_next;
            swap_pending_reg <= swap_pending_next;
            front_select_reg <= front_select_next;
            scan_column_reg  <= scan_column_next;
            scan_word_reg    <= scan_word_next;
            pwm_phase_reg    <= pwm_phase_next;
        end
    end

endmodule : lmps_front

`default_nettype wire

@@ hw/rtl/lmps_queue.sv @@
// Short queue of classified work items between the front and back parts.
`default_nettype none

module lmps_queue
    import lmps_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  op_t       push_op,
    output logic      full,
    input  wire logic pop,
    output op_t       head,
    output logic      not_empty
);

    op_t                      entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_PTR_W:0]     count_reg, count_next;

    assign full      = (count_reg == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];

    // Pointer and fill count updates.
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule : lmps_queue

`default_nettype wire

@@ hw/rtl/lmps_back.sv @@
// Back part: frame buffer banks, pixel compare and the held output register.
`default_nettype none

module lmps_back
    import lmps_pkg::*;
#(
    parameter int BUFFER_BYTES = 32
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  op_t       head,
    input  wire logic head_valid,
    output logic      pop,
    output logic      out_valid,
    input  wire logic out_stall,
    output logic [7:0] shift_out,
    output logic [7:0] row_drive,
    output logic [7:0] column_drive
);

    localparam int WORDS  = BUFFER_BYTES / BYTE_LANES;
    localparam int WORD_W = $clog2(WORDS);

    logic [7:0] lane_byte [BUFFER_COUNT][BYTE_LANES];
    logic       lane_vld  [BUFFER_COUNT][BYTE_LANES];

    logic       s1_valid_reg;
    op_t        s1_op_reg;
    logic       out_valid_reg;
    logic [7:0] shift_hold_reg, shift_hold_next;
    logic [7:0] row_hold_reg, row_hold_next;
    logic [7:0] column_hold_reg, column_hold_next;

    logic       advance;
    logic [7:0] pixel_byte [BYTE_LANES];
    logic [7:0] row_bits;

    logic [WORD_W-1:0] wr_addr;
    logic [WORD_W-1:0] rd_addr;

    assign wr_addr = head.wr_word[WORD_W-1:0];
    assign rd_addr = head.rd_word[WORD_W-1:0];

    // The stage moves when the output register is free or being taken.
    assign advance = !out_valid_reg || !out_stall;
    assign pop     = head_valid && (!s1_valid_reg || advance);

    // One bank per buffer and byte lane: one write and one registered read a cycle, on each pop.
    for (genvar gb = 0; gb < BUFFER_COUNT; gb++)
    begin : g_buf
        for (genvar gl = 0; gl < BYTE_LANES; gl++)
        begin : g_lane
            logic [7:0]       bank_mem [WORDS];
            logic [WORDS-1:0] bank_vld_reg;
            logic [7:0]       rd_data_reg;
            logic             rd_vld_reg;
            logic             wr_hit;

            assign wr_hit = pop && (head.kind == OP_WRITE) && (head.buf_sel == 1'(gb))
                          && (head.wr_lane == LANE_W'(gl));

            // Bank storage and registered read.
            always_ff @(posedge clk)
            begin
                if (wr_hit)
                begin
                    bank_mem[wr_addr] <= head.data;
                end
                if (pop)
                begin
                    rd_data_reg <= bank_mem[rd_addr];
                end
            end

            // Written marks; an unmarked entry still holds its reset image.
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    bank_vld_reg <= '0;
                    rd_vld_reg   <= 1'b0;
                end
                else
                begin
                    if (wr_hit)
                    begin
                        bank_vld_reg[wr_addr] <= 1'b1;
                    end
                    if (pop)
                    begin
                        rd_vld_reg <= bank_vld_reg[rd_addr];
                    end
                end
            end

            assign lane_byte[gb][gl] = rd_data_reg;
            assign lane_vld[gb][gl]  = rd_vld_reg;
        end
    end

    // Resolve each lane of the selected buffer against its reset image.
    always_comb
    begin
        for (int l = 0; l < BYTE_LANES; l++)
        begin
            pixel_byte[l] = lane_vld[s1_op_reg.buf_sel][l] ? lane_byte[s1_op_reg.buf_sel][l]
                          : init_byte(s1_op_reg.buf_sel, s1_op_reg.rd_word);
        end
    end

    // Row k lights when its nibble is above the current PWM phase.
    always_comb
    begin
        for (int j = 0; j < BYTE_LANES; j++)
        begin
            row_bits[2*j]     = ({4'h0, pixel_byte[j][3:0]} > s1_op_reg.phase);
            row_bits[2*j + 1] = ({4'h0, pixel_byte[j][7:4]} > s1_op_reg.phase);
        end
    end

    // Next held output values.
    always_comb
    begin
        shift_hold_next  = shift_hold_reg;
        row_hold_next    = row_hold_reg;
        column_hold_next = column_hold_reg;
        if (advance && s1_valid_reg)
        begin
            case (s1_op_reg.kind)
                OP_WRITE:
                begin
                    shift_hold_next = pixel_byte[s1_op_reg.rd_lane];
                end
                OP_SCAN:
                begin
                    row_hold_next    = row_bits;
                    column_hold_next = s1_op_reg.col_drive;
                end
                default:
                begin
                    shift_hold_next = shift_hold_reg;
                end
            endcase
        end
    end

    // Read stage and output register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            shift_hold_reg  <= '0;
            row_hold_reg    <= '0;
            column_hold_reg <= '0;
        end
        else
        begin
            if (pop)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= s1_valid_reg;
            end
            shift_hold_reg  <= shift_hold_next;
            row_hold_reg    <= row_hold_next;
            column_hold_reg <= column_hold_next;
        end
    end

    // Work item in the read stage.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_op_reg <= head;
        end
    end

    assign out_valid    = out_valid_reg;
    assign shift_out    = shift_hold_reg;
    assign row_drive    = row_hold_reg;
    assign column_drive = column_hold_reg;

endmodule : lmps_back

`default_nettype wire

@@ hw/rtl/led_matrix_pwm_scanner.sv @@
// Top level of the LED matrix PWM scanner: front part, queue and back part.
`default_nettype none

// Double-buffered 8x8 LED matrix driver with 4-bit PWM and a daisy-chained SPI
// byte stream. Each input transaction is either a received SPI byte (mode 0),
// which is written into the back buffer and loads the next back-buffer byte
// onto shift_out, or a scan tick (mode 1), which either swaps the buffers at
// the start of a frame or drives one column. Every input transaction yields
// exactly one output transaction carrying the held shift_out, row_drive and
// column_drive values. The block sustains one transaction per cycle while
// out_stall is low; a result passes through the decoupling queue register,
// the registered read of the buffer banks and the output register. Each
// buffer is split into four byte-lane banks, so a scan tick reads a whole
// column word in one access while an SPI byte writes one lane and reads
// another. Buffers come out of reset holding their start image at once
// (written marks per byte, no clearing pass). BUFFER_BYTES must be a
// multiple of four.
module led_matrix_pwm_scanner
    import lmps_pkg::*;
#(
    parameter int BUFFER_BYTES = 32,
    parameter int COLUMNS      = 8,
    parameter int PWM_LEVELS   = 16
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic       mode,
    input  wire logic [7:0] data_in,
    input  wire logic       select_high,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      shift_out,
    output logic [7:0]      row_drive,
    output logic [7:0]      column_drive
);

    logic accept;
    logic queue_full;
    logic queue_pop;
    logic queue_not_empty;
    op_t  front_op;
    op_t  queue_head;

    // Input transactions are taken whenever the queue has room.
    assign in_stall = queue_full;
    assign accept   = in_valid && !queue_full;

    lmps_front #(
        .BUFFER_BYTES (BUFFER_BYTES),
        .COLUMNS      (COLUMNS),
        .PWM_LEVELS   (PWM_LEVELS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .mode        (mode),
        .data_in     (data_in),
        .select_high (select_high),
        .op          (front_op)
    );

    lmps_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_op   (front_op),
        .full      (queue_full),
        .pop       (queue_pop),
        .head      (queue_head),
        .not_empty (queue_not_empty)
    );

    lmps_back #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (queue_head),
        .head_valid   (queue_not_empty),
        .pop          (queue_pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .shift_out    (shift_out),
        .row_drive    (row_drive),
        .column_drive (column_drive)
    );

endmodule : led_matrix_pwm_scanner

`default_nettype wire

@@ hw/rtl/lmps_checker.sv @@
// Port-level assertions for the LED matrix PWM scanner and their binding.
`default_nettype none

module lmps_checker
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_stall,
    input wire logic       mode,
    input wire logic [7:0] data_in,
    input wire logic       select_high,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [7:0] shift_out,
    input wire logic [7:0] row_drive,
    input wire logic [7:0] column_drive
);

    // A stalled input transaction stays offered with the same payload.
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(mode) && $stable(data_in)
                                 && $stable(select_high))
        else $error("input transaction changed while stalled");

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result withdrawn while stalled");

    // A stalled result keeps its payload.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(shift_out) && $stable(row_drive)
                                   && $stable(column_drive))
        else $error("result payload changed while stalled");

    // Held outputs only change together with a newly offered result.
    a_hold_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |=> out_valid || ($stable(shift_out) && $stable(row_drive)
                                     && $stable(column_drive)))
        else $error("held outputs changed with no result offered");

    // The column select is the reset value, all off, or exactly one column low.
    a_one_column: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (column_drive == 8'h00) || (column_drive == 8'hFF)
                      || ($countones(~column_drive) == 1))
        else $error("more than one column selected");

endmodule : lmps_checker

bind led_matrix_pwm_scanner lmps_checker u_lmps_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .mode         (mode),
    .data_in      (data_in),
    .select_high  (select_high),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .shift_out    (shift_out),
    .row_drive    (row_drive),
    .column_drive (column_drive)
);

`default_nettype wire
